[hdl/pcd_pkg.sv]
package pcd_pkg;

  localparam int BYTE_W  = 8;
  localparam int REQ_W   = 2;
  localparam int ENTRY_W = 24;
  localparam int ADDR_W  = 9;

  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BODY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] PH_CMD    = 2'd0;
  localparam logic [1:0] PH_SOURCE = 2'd1;
  localparam logic [1:0] PH_GREEN  = 2'd2;
  localparam logic [1:0] PH_BLUE   = 2'd3;

  localparam int CMD_KEEP_BIT = 7;
  localparam int CMD_COPY_BIT = 6;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_RUN_RD = 5'b00100,
    ST_RUN_WR = 5'b01000,
    ST_FINISH = 5'b10000
  } pcd_state_t;

endpackage

[hdl/pcd_req_if.sv]
interface pcd_req_if;
  logic                          valid;
  logic                          ready;
  logic [pcd_pkg::REQ_W-1:0]     req_type;
  logic [pcd_pkg::BYTE_W-1:0]    data_byte;
  logic [pcd_pkg::BYTE_W-1:0]    read_index;

  modport source (output valid, req_type, data_byte, read_index, input ready);
  modport sink   (input valid, req_type, data_byte, read_index, output ready);
endinterface

[hdl/pcd_rsp_if.sv]
interface pcd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pcd_pkg::BYTE_W-1:0]    red;
  logic [pcd_pkg::BYTE_W-1:0]    green;
  logic [pcd_pkg::BYTE_W-1:0]    blue;
  logic                          palette_complete;

  modport source (output valid, red, green, blue, palette_complete, input ready);
  modport sink   (input valid, red, green, blue, palette_complete, output ready);
endinterface

[hdl/palette_chunk_decoder.sv]
// Palette chunk decoder. Every request gives exactly one response. Two banks of
// 256 RGB entries share one memory with one read and one write port; new
// entries go to the bank that is not current, which becomes current when
// PALETTE_ENTRIES entries have been filled. After reset a clearing pass zeroes
// the memory, during which no request is taken. One request is handled at a
// time: a start, literal, copy-header or read byte goes straight to the finish
// state, and a keep run (up to 128 entries) or copy run (up to 64 entries) does
// one memory read then one write per entry, stopping early if the bank fills.
// A finished response waits in an output register while the next request is
// taken; the next response loads once that register is free.
module palette_chunk_decoder #(
  parameter int PALETTE_ENTRIES = 256
) (
  input logic      clk,
  input logic      rst,
  pcd_req_if.sink  req,
  pcd_rsp_if.source rsp
);

  localparam int FW = $clog2(PALETTE_ENTRIES + 1);

  pcd_pkg::pcd_state_t state;

  logic [pcd_pkg::ENTRY_W-1:0] mem [0:(1 << pcd_pkg::ADDR_W)-1];
  logic [pcd_pkg::ENTRY_W-1:0] mem_q;

  logic                        wr_en;
  logic [pcd_pkg::ADDR_W-1:0]  wr_addr;
  logic [pcd_pkg::ENTRY_W-1:0] wr_data;
  logic                        rd_en;
  logic [pcd_pkg::ADDR_W-1:0]  rd_addr;

  logic [pcd_pkg::ADDR_W-1:0]  clr_addr;
  logic                        current_bank;
  logic [1:0]                  parse_phase;
  logic [FW-1:0]               filled;
  logic [FW-1:0]               filled_next;
  logic                        full;
  logic                        done_flag;
  logic [5:0]                  copy_length;
  logic [6:0]                  run_left;
  logic [7:0]                  run_src;
  logic [15:0]                 literal_hold;
  logic                        rd_req;

  logic                        rsp_valid;
  logic                        rsp_load;
  logic [7:0]                  res_red;
  logic [7:0]                  res_green;
  logic [7:0]                  res_blue;
  logic                        res_complete;

  logic                        req_xfer;
  logic [pcd_pkg::ADDR_W-1:0]  dst_addr;

  assign req.ready   = (state == pcd_pkg::ST_IDLE);
  assign req_xfer    = req.valid && req.ready;
  assign filled_next = filled + 1'b1;
  assign full        = (filled_next == FW'(PALETTE_ENTRIES));
  assign dst_addr    = {~current_bank, 8'(filled)};
  assign rsp_load    = (state == pcd_pkg::ST_FINISH) && (!rsp_valid || rsp.ready);

  assign rsp.valid            = rsp_valid;
  assign rsp.red              = res_red;
  assign rsp.green            = res_green;
  assign rsp.blue             = res_blue;
  assign rsp.palette_complete = res_complete;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      pcd_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      pcd_pkg::ST_IDLE: begin
        if (req_xfer && req.req_type == pcd_pkg::REQ_READ) begin
          rd_en   = 1'b1;
          rd_addr = {current_bank, req.read_index};
        end
        if (req_xfer && req.req_type == pcd_pkg::REQ_BODY && !done_flag &&
            parse_phase == pcd_pkg::PH_BLUE) begin
          wr_en   = 1'b1;
          wr_addr = dst_addr;
          wr_data = {literal_hold, req.data_byte};
        end
      end
      pcd_pkg::ST_RUN_RD: begin
        rd_en   = 1'b1;
        rd_addr = {current_bank, run_src};
      end
      pcd_pkg::ST_RUN_WR: begin
        wr_en   = 1'b1;
        wr_addr = dst_addr;
        wr_data = mem_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pcd_pkg::ST_CLEAR;
      clr_addr     <= '0;
      current_bank <= 1'b0;
      parse_phase  <= pcd_pkg::PH_CMD;
      filled       <= '0;
      done_flag    <= 1'b0;
      copy_length  <= '0;
      run_left     <= '0;
      run_src      <= '0;
      literal_hold <= '0;
      rd_req       <= 1'b0;
      rsp_valid    <= 1'b0;
      res_red      <= '0;
      res_green    <= '0;
      res_blue     <= '0;
      res_complete <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        pcd_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= pcd_pkg::ST_IDLE;
          end
        end
        pcd_pkg::ST_IDLE: begin
          if (req_xfer) begin
            rd_req <= (req.req_type == pcd_pkg::REQ_READ);
            case (req.req_type)
              pcd_pkg::REQ_START: begin
                parse_phase <= pcd_pkg::PH_CMD;
                filled      <= '0;
                done_flag   <= 1'b0;
                state       <= pcd_pkg::ST_FINISH;
              end
              pcd_pkg::REQ_BODY: begin
                if (done_flag) begin
                  state <= pcd_pkg::ST_FINISH;
                end else begin
                  case (parse_phase)
                    pcd_pkg::PH_CMD: begin
                      if (req.data_byte[pcd_pkg::CMD_KEEP_BIT]) begin
                        run_src  <= 8'(filled);
                        run_left <= req.data_byte[6:0];
                        state    <= pcd_pkg::ST_RUN_RD;
                      end else if (req.data_byte[pcd_pkg::CMD_COPY_BIT]) begin
                        copy_length <= req.data_byte[5:0];
                        parse_phase <= pcd_pkg::PH_SOURCE;
                        state       <= pcd_pkg::ST_FINISH;
                      end else begin
                        literal_hold <= {req.data_byte, 8'h00};
                        parse_phase  <= pcd_pkg::PH_GREEN;
                        state        <= pcd_pkg::ST_FINISH;
                      end
                    end
                    pcd_pkg::PH_SOURCE: begin
                      run_src     <= req.data_byte;
                      run_left    <= {1'b0, copy_length};
                      parse_phase <= pcd_pkg::PH_CMD;
                      state       <= pcd_pkg::ST_RUN_RD;
                    end
                    pcd_pkg::PH_GREEN: begin
                      literal_hold <= {literal_hold[15:8], req.data_byte};
                      parse_phase  <= pcd_pkg::PH_BLUE;
                      state        <= pcd_pkg::ST_FINISH;
                    end
                    default: begin
                      parse_phase <= pcd_pkg::PH_CMD;
                      filled      <= filled_next;
                      state       <= pcd_pkg::ST_FINISH;
                      if (full) begin
                        current_bank <= ~current_bank;
                        done_flag    <= 1'b1;
                      end
                    end
                  endcase
                end
              end
              default: begin
                state <= pcd_pkg::ST_FINISH;
              end
            endcase
          end
        end
        pcd_pkg::ST_RUN_RD: begin
          state <= pcd_pkg::ST_RUN_WR;
        end
        pcd_pkg::ST_RUN_WR: begin
          filled  <= filled_next;
          run_src <= run_src + 1'b1;
          if (full) begin
            current_bank <= ~current_bank;
            done_flag    <= 1'b1;
            parse_phase  <= pcd_pkg::PH_CMD;
            state        <= pcd_pkg::ST_FINISH;
          end else if (run_left == '0) begin
            state <= pcd_pkg::ST_FINISH;
          end else begin
            run_left <= run_left - 1'b1;
            state    <= pcd_pkg::ST_RUN_RD;
          end
        end
        pcd_pkg::ST_FINISH: begin
          if (rsp_load) begin
            res_red      <= rd_req ? {mem_q[21:16], 2'b00} : 8'h00;
            res_green    <= rd_req ? {mem_q[13:8], 2'b00} : 8'h00;
            res_blue     <= rd_req ? {mem_q[5:0], 2'b00} : 8'h00;
            res_complete <= done_flag;
            state        <= pcd_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= pcd_pkg::ST_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= FW'(PALETTE_ENTRIES))
    else $error("fill count past palette size");

  a_done_full: assert property (@(posedge clk) disable iff (rst)
    done_flag |-> filled == FW'(PALETTE_ENTRIES))
    else $error("palette complete without a full bank");

  a_wr_bank: assert property (@(posedge clk) disable iff (rst)
    wr_en && state != pcd_pkg::ST_CLEAR |-> wr_addr[pcd_pkg::ADDR_W-1] != current_bank)
    else $error("write into the current bank");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    state == pcd_pkg::ST_RUN_WR |-> $past(state) == pcd_pkg::ST_RUN_RD)
    else $error("run write without a preceding read");

endmodule
